### hdl/owbm_pkg.sv
// Package for the one-wire bus master: command and phase codes, the
// queued item type, configuration register layout and reset values.
// No dependencies; imported by every module of the block.
package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BYTE_W        = BITS_PER_BYTE;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int TIME_W        = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 16;
    localparam int MODE_W        = 2;
    localparam int OUT_USED_W    = 4 + BYTE_W;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [MODE_W-1:0] {
        OP_NONE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LOW     = 2'd1,
        PH_RELEASE = 2'd2,
        PH_RECOVER = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_RECOVER = 3'd2,
        CFG_SHORT         = 3'd3,
        CFG_LONG          = 3'd4,
        CFG_READ_RECOVER  = 3'd5
    } t_cfg_idx;

    localparam t_time RST_RESET_LOW     = 10'd500;
    localparam t_time RST_PRESENCE_WAIT = 10'd40;
    localparam t_time RST_RESET_RECOVER = 10'd240;
    localparam t_time RST_SHORT         = 10'd10;
    localparam t_time RST_LONG          = 10'd50;
    localparam t_time RST_READ_RECOVER  = 10'd60;

    typedef struct packed {
        t_time reset_low;
        t_time presence_wait;
        t_time reset_recover;
        t_time short_t;
        t_time long_t;
        t_time read_recover;
    } t_cfg;

    typedef struct packed {
        t_op   op;
        t_byte write_value;
        logic  line_level;
    } t_item;

endpackage

### hdl/owbm_front.sv
// Front end of the one-wire bus master: takes tick beats, decodes the
// command field and holds them in a two-entry queue for the engine.
// Depends on owbm_pkg.
module owbm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] mode, [9:2] write_value, [10] line_level, [15:11] zero
    input  logic [owbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                o_item_valid,
    input  logic                                i_item_ready,
    output owbm_pkg::t_item                     o_item
);
    import owbm_pkg::*;

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_item      in_item;

    assign in_item.op          = t_op'(s_axis_tdata[MODE_W-1:0]);
    assign in_item.write_value = s_axis_tdata[MODE_W +: BYTE_W];
    assign in_item.line_level  = s_axis_tdata[MODE_W + BYTE_W];

    assign s_axis_tready = (r_count != 2'd2);
    assign o_item_valid  = (r_count != 2'd0);
    assign o_item        = r_slot[r_rd_ptr];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = o_item_valid && i_item_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_item;
        end
    end

endmodule

### hdl/owbm_engine.sv
// Back end of the one-wire bus master: configuration registers, the slot
// timing state machine and the registered result beat.
// Depends on owbm_pkg.
module owbm_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [owbm_pkg::TIME_W-1:0]         i_cfg_wdata,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  owbm_pkg::t_item                     i_item,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
    // [11:4] read_value, [15:12] zero
    output logic [owbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import owbm_pkg::*;

    t_cfg                 r_cfg;
    t_phase               r_phase,    n_phase;
    t_time                r_time,     n_time;
    logic [BIT_IDX_W-1:0] r_bit,      n_bit;
    t_byte                r_shift,    n_shift;
    t_op                  r_op,       n_op;
    logic                 r_presence, n_presence;
    t_byte                r_read,     n_read;
    logic                 n_done;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 step;

    function automatic t_time ticks(input t_time d);
        return (d == '0) ? '0 : d - TIME_W'(1);
    endfunction

    function automatic t_time low_time(input t_op op, input t_byte sh, input t_cfg c);
        t_time d;
        unique case (op)
            OP_RESET: d = c.reset_low;
            OP_WRITE: d = sh[0] ? c.short_t : c.long_t;
            default:  d = c.short_t;
        endcase
        return ticks(d);
    endfunction

    assign o_item_ready  = !r_out_valid || m_axis_tready;
    assign step          = i_item_valid && o_item_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_phase    = r_phase;
        n_time     = r_time;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_op       = r_op;
        n_presence = r_presence;
        n_read     = r_read;
        n_done     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.op != OP_NONE) begin
                    n_op    = i_item.op;
                    n_bit   = '0;
                    n_shift = (i_item.op == OP_WRITE) ? i_item.write_value : '0;
                    n_phase = PH_LOW;
                    n_time  = low_time(n_op, n_shift, r_cfg);
                end
            end
            default: begin
                if (r_time != '0) begin
                    n_time = r_time - TIME_W'(1);
                end else if (r_phase == PH_LOW) begin
                    n_phase = PH_RELEASE;
                    unique case (r_op)
                        OP_RESET: n_time = ticks(r_cfg.presence_wait);
                        OP_WRITE: n_time = ticks(r_shift[0] ? r_cfg.long_t : r_cfg.short_t);
                        default:  n_time = ticks(r_cfg.short_t);
                    endcase
                end else if (r_phase == PH_RELEASE && r_op == OP_RESET) begin
                    n_presence = !i_item.line_level;
                    n_phase    = PH_RECOVER;
                    n_time     = ticks(r_cfg.reset_recover);
                end else if (r_phase == PH_RELEASE && r_op == OP_READ) begin
                    n_shift = {i_item.line_level, r_shift[BYTE_W-1:1]};
                    n_phase = PH_RECOVER;
                    n_time  = ticks(r_cfg.read_recover);
                end else if (r_phase == PH_RECOVER && r_op == OP_RESET) begin
                    n_phase = PH_IDLE;
                    n_time  = '0;
                    n_done  = 1'b1;
                end else begin
                    // End of a bit slot: a write shifts here, then the next
                    // bit starts or the byte is complete.
                    if (r_phase == PH_RELEASE) begin
                        n_shift = {1'b0, r_shift[BYTE_W-1:1]};
                    end
                    if (r_bit == LAST_BIT) begin
                        if (r_op == OP_READ) begin
                            n_read = n_shift;
                        end
                        n_phase = PH_IDLE;
                        n_time  = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_bit   = r_bit + BIT_IDX_W'(1);
                        n_phase = PH_LOW;
                        n_time  = low_time(r_op, n_shift, r_cfg);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RST_RESET_LOW;
            r_cfg.presence_wait <= RST_PRESENCE_WAIT;
            r_cfg.reset_recover <= RST_RESET_RECOVER;
            r_cfg.short_t       <= RST_SHORT;
            r_cfg.long_t        <= RST_LONG;
            r_cfg.read_recover  <= RST_READ_RECOVER;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_wdata;
                CFG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_wdata;
                CFG_RESET_RECOVER: r_cfg.reset_recover <= i_cfg_wdata;
                CFG_SHORT:         r_cfg.short_t       <= i_cfg_wdata;
                CFG_LONG:          r_cfg.long_t        <= i_cfg_wdata;
                CFG_READ_RECOVER:  r_cfg.read_recover  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_op        <= OP_NONE;
            r_presence  <= 1'b0;
            r_read      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase    <= n_phase;
                r_time     <= n_time;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_op       <= n_op;
                r_presence <= n_presence;
                r_read     <= n_read;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {(OUT_DATA_W - OUT_USED_W)'(0), n_read, n_presence, n_done,
                           (n_phase != PH_IDLE), (n_phase == PH_LOW)};
        end
    end

endmodule

### hdl/one_wire_bus_master.sv
// Top level of the one-wire bus master: front queue and timing engine.
// Depends on owbm_pkg, owbm_front and owbm_engine.
//
// Each input beat is one bus tick carrying a command request and the sampled
// line level; each tick yields exactly one result beat with the line drive,
// busy, done, presence and last read byte. The block takes one beat per clock
// cycle when the result side is ready; a tick passes the two-entry front queue
// and then the registered result stage. The user must write timing registers
// through the configuration port only while idle; the block does not enforce it.
module one_wire_bus_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [owbm_pkg::TIME_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] mode, [9:2] write_value, [10] line_level, [15:11] zero
    input  logic [owbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
    // [11:4] read_value, [15:12] zero
    output logic [owbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import owbm_pkg::*;

    logic  item_valid;
    logic  item_ready;
    t_item item;

    owbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_item_valid  (item_valid),
        .i_item_ready  (item_ready),
        .o_item        (item)
    );

    owbm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item_valid  (item_valid),
        .o_item_ready  (item_ready),
        .i_item        (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hdl/owbm_checker.sv
// Port-level checks for the one-wire bus master.
// Depends on owbm_pkg; bound to one_wire_bus_master.
module owbm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [owbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import owbm_pkg::*;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[1]))
        else $error("done and busy shown in the same beat");

    a_drive_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("line driven low while not busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present right after reset");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
